[src/assert_macros.svh]
// Assertion macros for the RTL files that carry concurrent checks.
// Depends on nothing; each file that asserts includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, switched off while reset is held.
`define CLPB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CLPB_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

[src/clpb_pkg.sv]
// Shared types and constants of the cutoff pair list builder.
// Used by the axis distance unit and the top level; depends on nothing.
package clpb_pkg;

	localparam int POS_W             = 32;
	localparam int BOX_W             = 31;
	localparam int CUT_W             = 63;
	localparam int ATOM_W            = 16;
	localparam int PIDX_W            = 17;
	localparam int SCR_W             = 16;
	localparam int IDX_W             = 6;
	localparam int SQ_W              = 2 * POS_W;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 63;
	localparam int MAX_PARTICLES_DEF = 64;

	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN    = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Squared wrapped axis difference, with a flag for a magnitude too large
	// to square within the result width.
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            sat;
	} axis_sq_t;

endpackage

[src/clpb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module clpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/clpb_axis.sv]
// Pipelined minimum-image square of one axis: difference, wrap, magnitude, square.
// Depends on clpb_pkg; four stages, all advancing together on adv.
module clpb_axis
	import clpb_pkg::*;
(
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [POS_W-1:0] a,
	input  logic signed [POS_W-1:0] b,
	input  logic [BOX_W-1:0]        box,
	output axis_sq_t                res
);

	localparam int D_W = POS_W + 1;
	localparam int W_W = POS_W + 2;

	logic signed [D_W-1:0] d_s2;
	logic signed [W_W-1:0] w_s3;
	logic [POS_W-1:0]      mag_s4;
	logic                  sat_s4;
	logic [SQ_W-1:0]       sq_s5;
	logic                  sat_s5;

	logic signed [D_W-1:0] d_d;
	logic signed [W_W-1:0] d_ext;
	logic signed [W_W-1:0] twice;
	logic signed [W_W-1:0] box_s;
	logic signed [W_W-1:0] w_d;
	logic [W_W-1:0]        mag_full;

	assign d_d = {a[POS_W-1], a} - {b[POS_W-1], b};

	always_comb begin
		d_ext = W_W'(d_s2);
		twice = {d_s2, 1'b0};
		box_s = W_W'(box);
		// A single wrap; positions are taken to lie inside the box.
		priority if (twice > box_s) begin
			w_d = d_ext - box_s;
		end else if (twice < -box_s) begin
			w_d = d_ext + box_s;
		end else begin
			w_d = d_ext;
		end
	end

	assign mag_full = w_s3[W_W-1] ? W_W'(-w_s3) : W_W'(w_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= d_d;
			w_s3   <= w_d;
			mag_s4 <= mag_full[POS_W-1:0];
			sat_s4 <= |mag_full[W_W-1:POS_W];
			sq_s5  <= mag_s4 * mag_s4;
			sat_s5 <= sat_s4;
		end
	end

	assign res.sq  = sq_s5;
	assign res.sat = sat_s5;

endmodule

[src/cutoff_pair_list_builder.sv]
// Cutoff pair list builder, top level: control, particle store and pair output.
// Depends on clpb_pkg, clpb_ram, clpb_axis and assert_macros.svh.
//
// Usage. Particles arrive on the input channel (in_valid/in_ready) and pairs
// leave on the output channel (out_valid/out_ready); a transfer happens when
// valid and ready are both high. Registers are written through cfg_we,
// cfg_index and cfg_wdata, by the user only while the block is idle; the
// block does not enforce this. A particle is taken only while the block is
// idle. It is written to the position store in the transfer cycle; a valid
// particle with index k then scans the k earlier entries, one store read per
// cycle while the pipeline is not frozen, limited by the single read port of
// the store, through a six-stage distance pipeline. An invalid, dropped or
// first particle starts no scan, and the block stays idle.
// Each hit is held back one place so that the last pair of an item can carry
// run_last. When the receiver stalls, the scan pipeline freezes as soon as a
// second pair has nowhere to go, and resumes when the output register is taken.
// Reset clears the configuration and control registers to zero and empties
// the list; the store itself needs no clearing pass, as only entries written
// since list start are read.
module cutoff_pair_list_builder
	import clpb_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     list_start,
	input  logic signed [PIDX_W-1:0] parent_index,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         first_index,
	output logic [IDX_W-1:0]         second_index,
	output logic [SCR_W-1:0]         pair_screening,
	output logic                     run_last
);

`include "assert_macros.svh"

	localparam int AW    = $clog2(MAX_PARTICLES);
	localparam int CW    = $clog2(MAX_PARTICLES + 1);
	localparam int RAM_W = 3 * POS_W + 1;
	localparam int SUM_W = SQ_W + 2;

	// Configuration registers.
	logic [CUT_W-1:0]  cutoff_q;
	logic [BOX_W-1:0]  box_x_q;
	logic [BOX_W-1:0]  box_y_q;
	logic [BOX_W-1:0]  box_z_q;
	logic [ATOM_W-1:0] active_q;
	logic [SCR_W-1:0]  screen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
			box_x_q  <= '0;
			box_y_q  <= '0;
			box_z_q  <= '0;
			active_q <= '0;
			screen_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUTOFF_SQ: cutoff_q <= cfg_wdata[CUT_W-1:0];
				REG_BOX_X:     box_x_q  <= cfg_wdata[BOX_W-1:0];
				REG_BOX_Y:     box_y_q  <= cfg_wdata[BOX_W-1:0];
				REG_BOX_Z:     box_z_q  <= cfg_wdata[BOX_W-1:0];
				REG_ACTIVE:    active_q <= cfg_wdata[ATOM_W-1:0];
				REG_SCREEN:    screen_q <= cfg_wdata[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state.
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cur_idx_q;
	logic [CW-1:0]     rd_q;
	logic [POS_W-1:0]  cur_x_q, cur_y_q, cur_z_q;
	logic              pend_q;
	logic [AW-1:0]     pend_j_q;

	logic              in_acc;
	logic [CW-1:0]     idx_w;
	logic              full;
	logic              pvalid;
	logic              start_scan;
	logic              issuing;
	logic              flush_emit;
	logic              drained;
	logic              adv;
	logic              hit;
	logic              out_free;
	logic              load_out;
	logic              pipe_busy;

	// Pipeline registers; the store's registered read is stage one.
	logic [RAM_W-1:0]  rdata_s1;
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [AW-1:0]     j_s1, j_s2, j_s3, j_s4, j_s5, j_s6;
	logic [SQ_W-1:0]   r2_s6;

	// Output register.
	logic              out_valid_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  second_q;
	logic [SCR_W-1:0]  scr_q;
	logic              last_q;

	assign in_acc     = in_valid && in_ready;
	assign idx_w      = list_start ? '0 : count_q;
	assign full       = (idx_w == CW'(MAX_PARTICLES));
	assign pvalid     = !parent_index[PIDX_W-1] && (parent_index[ATOM_W-1:0] < active_q);
	assign start_scan = in_acc && !full && pvalid && (idx_w != '0);
	assign out_free   = !out_valid_q || out_ready;
	assign hit        = vld_s6 && (r2_s6 < SQ_W'(cutoff_q));
	// A new hit while one is already held needs a free output register.
	assign adv        = !(hit && pend_q && !out_free);
	assign load_out   = (adv && hit && pend_q) || flush_emit;
	assign pipe_busy  = vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5 || vld_s6;
	assign drained    = !issuing && !pipe_busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (drained) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready   = 1'b0;
		issuing    = 1'b0;
		flush_emit = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  issuing = (rd_q < cur_idx_q);
			ST_FLUSH: flush_emit = pend_q && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_q     <= '0;
			pend_q   <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && !full) begin
				count_q <= idx_w + CW'(1);
			end
			if (start_scan) begin
				rd_q <= '0;
			end else if (adv && issuing) begin
				rd_q <= rd_q + CW'(1);
			end
			if (adv) begin
				vld_s1 <= issuing;
				vld_s2 <= vld_s1 && rdata_s1[RAM_W-1];
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
			end
			if (adv && hit) begin
				pend_q <= 1'b1;
			end else if (flush_emit) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			cur_idx_q <= idx_w;
			cur_x_q   <= pos_x;
			cur_y_q   <= pos_y;
			cur_z_q   <= pos_z;
		end
		if (adv) begin
			j_s1 <= rd_q[AW-1:0];
			j_s2 <= j_s1;
			j_s3 <= j_s2;
			j_s4 <= j_s3;
			j_s5 <= j_s4;
			j_s6 <= j_s5;
		end
		if (adv && hit) begin
			pend_j_q <= j_s6;
		end
		if (load_out) begin
			first_q  <= IDX_W'(pend_j_q);
			second_q <= IDX_W'(cur_idx_q);
			scr_q    <= screen_q;
			last_q   <= flush_emit;
		end
	end

	// Particle store: valid flag above the three coordinates.
	clpb_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_PARTICLES)
	) u_store (
		.clk  (clk),
		.we   (in_acc && !full),
		.waddr(idx_w[AW-1:0]),
		.wdata({pvalid, pos_z, pos_y, pos_x}),
		.re   (adv && issuing),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata_s1)
	);

	axis_sq_t sq_x, sq_y, sq_z;

	clpb_axis u_axis_x (
		.clk(clk),
		.adv(adv),
		.a  (cur_x_q),
		.b  (rdata_s1[POS_W-1:0]),
		.box(box_x_q),
		.res(sq_x)
	);

	clpb_axis u_axis_y (
		.clk(clk),
		.adv(adv),
		.a  (cur_y_q),
		.b  (rdata_s1[2*POS_W-1:POS_W]),
		.box(box_y_q),
		.res(sq_y)
	);

	clpb_axis u_axis_z (
		.clk(clk),
		.adv(adv),
		.a  (cur_z_q),
		.b  (rdata_s1[3*POS_W-1:2*POS_W]),
		.box(box_z_q),
		.res(sq_z)
	);

	// Saturating sum of the three squares.
	logic [SUM_W-1:0] sum_d;

	assign sum_d = SUM_W'(sq_x.sq) + SUM_W'(sq_y.sq) + SUM_W'(sq_z.sq);

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s6 <= (sq_x.sat || sq_y.sat || sq_z.sat || (|sum_d[SUM_W-1:SQ_W])) ?
				'1 : sum_d[SQ_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign first_index    = first_q;
	assign second_index   = second_q;
	assign pair_screening = scr_q;
	assign run_last       = last_q;

	`CLPB_ASSERT(a_idle_empty, clk, arst_n, in_ready |-> !pipe_busy, "particle taken while scanning")
	`CLPB_NEVER(a_no_overwrite, clk, arst_n, load_out && !out_free, "untaken pair overwritten")
	`CLPB_ASSERT(a_flush_done, clk, arst_n, (state_q == ST_FLUSH) |-> (rd_q == cur_idx_q), "scan unfinished")
	`CLPB_NEVER(a_idle_no_pend, clk, arst_n, (state_q == ST_IDLE) && pend_q, "held pair left behind")

endmodule

[sim/tb.sv]
// Self-checking testbench for cutoff_pair_list_builder: directed and random particle lists
// are checked pair by pair against a minimum-image distance predictor held in a small class.
// Depends on clpb_pkg and the cutoff_pair_list_builder RTL.
module tb
	import clpb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXP         = MAX_PARTICLES_DEF;
	localparam int ONE_NM       = 1 << 16;
	localparam int SETTLE       = MAXP + 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                     start;
		logic signed [PIDX_W-1:0] parent;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic signed [POS_W-1:0]  z;
	} particle_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] second_idx;
		logic [SCR_W-1:0] screen;
		logic             last_flag;
	} pair_t;

	typedef struct packed {
		logic [CUT_W-1:0]  cutoff;
		logic [BOX_W-1:0]  box_x;
		logic [BOX_W-1:0]  box_y;
		logic [BOX_W-1:0]  box_z;
		logic [ATOM_W-1:0] active;
		logic [SCR_W-1:0]  screen;
	} regs_t;

	class pair_list_model;
		logic [CUT_W-1:0]        cutoff_sq;
		logic [BOX_W-1:0]        box_x, box_y, box_z;
		logic [ATOM_W-1:0]       active_atoms;
		logic [SCR_W-1:0]        screening;
		logic signed [POS_W-1:0] x_at [MAXP];
		logic signed [POS_W-1:0] y_at [MAXP];
		logic signed [POS_W-1:0] z_at [MAXP];
		bit                      slot_live [MAXP];
		int                      fill;
		pair_t                   due_pairs [$];
		int                      mismatches;

		function new();
			cutoff_sq = '0;
			box_x = '0;
			box_y = '0;
			box_z = '0;
			active_atoms = '0;
			screening = '0;
			fill = 0;
			mismatches = 0;
			foreach (slot_live[k])
				slot_live[k] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CUTOFF_SQ: cutoff_sq = val[CUT_W-1:0];
				REG_BOX_X:     box_x = val[BOX_W-1:0];
				REG_BOX_Y:     box_y = val[BOX_W-1:0];
				REG_BOX_Z:     box_z = val[BOX_W-1:0];
				REG_ACTIVE:    active_atoms = val[ATOM_W-1:0];
				REG_SCREEN:    screening = val[SCR_W-1:0];
				default: ;
			endcase
		endfunction

		// One conditional wrap by the box length, then the square; a magnitude of
		// 2^32 or more saturates the whole square.
		function longint unsigned wrapped_sq(logic signed [POS_W-1:0] a,
				logic signed [POS_W-1:0] b, logic [BOX_W-1:0] span);
			longint d;
			longint bl;
			longint unsigned mag;
			d = longint'(a) - longint'(b);
			bl = span;
			if (2 * d > bl)
				d = d - bl;
			else if (2 * d < -bl)
				d = d + bl;
			mag = (d < 0) ? -d : d;
			if (mag >= 64'h1_0000_0000)
				return '1;
			return mag * mag;
		endfunction

		function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
			longint unsigned s;
			s = a + b;
			return (s < a) ? '1 : s;
		endfunction

		function void take_particle(particle_t p);
			int slot;
			bit live;
			longint unsigned r2;
			int hits [$];
			pair_t e;
			if (p.start) begin
				foreach (slot_live[k])
					slot_live[k] = 1'b0;
				fill = 0;
			end
			if (fill >= MAXP)
				return;
			slot = fill;
			fill++;
			live = !p.parent[PIDX_W-1] && (p.parent[ATOM_W-1:0] < active_atoms);
			x_at[slot] = p.x;
			y_at[slot] = p.y;
			z_at[slot] = p.z;
			slot_live[slot] = live;
			if (!live)
				return;
			for (int j = 0; j < slot; j++) begin
				if (!slot_live[j])
					continue;
				r2 = wrapped_sq(p.x, x_at[j], box_x);
				r2 = sat_sum(r2, wrapped_sq(p.y, y_at[j], box_y));
				r2 = sat_sum(r2, wrapped_sq(p.z, z_at[j], box_z));
				if (r2 < cutoff_sq)
					hits = {hits, j};
			end
			foreach (hits[k]) begin
				e.first_idx = IDX_W'(hits[k]);
				e.second_idx = IDX_W'(slot);
				e.screen = screening;
				e.last_flag = (k == hits.size() - 1);
				due_pairs = {due_pairs, e};
			end
		endfunction

		function void match_pair(pair_t got);
			pair_t want;
			if (due_pairs.size() == 0) begin
				$error("pair %0d-%0d arrived with nothing due", got.first_idx, got.second_idx);
				mismatches++;
				return;
			end
			want = due_pairs.pop_front();
			if (got.first_idx != want.first_idx) begin
				$error("first_index: expected %0d, got %0d", want.first_idx, got.first_idx);
				mismatches++;
			end
			if (got.second_idx != want.second_idx) begin
				$error("second_index: expected %0d, got %0d", want.second_idx, got.second_idx);
				mismatches++;
			end
			if (got.screen != want.screen) begin
				$error("pair_screening: expected %0h, got %0h", want.screen, got.screen);
				mismatches++;
			end
			if (got.last_flag != want.last_flag) begin
				$error("run_last: expected %0d, got %0d", want.last_flag, got.last_flag);
				mismatches++;
			end
		endfunction

		function int due_count();
			return due_pairs.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_wdata;
	logic                     in_valid;
	logic                     in_ready;
	logic                     list_start;
	logic signed [PIDX_W-1:0] parent_index;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic                     out_valid;
	logic                     out_ready;
	logic [IDX_W-1:0]         first_index;
	logic [IDX_W-1:0]         second_index;
	logic [SCR_W-1:0]         pair_screening;
	logic                     run_last;

	bit             hold_request;
	bit             in_calm;
	pair_list_model pair_list;

	cutoff_pair_list_builder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.list_start     (list_start),
		.parent_index   (parent_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.first_index    (first_index),
		.second_index   (second_index),
		.pair_screening (pair_screening),
		.run_last       (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic particle_t make_particle(logic start, int parent, int x, int y, int z);
		particle_t p;
		p.start = start;
		p.parent = PIDX_W'(parent);
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic regs_t make_regs(logic [CUT_W-1:0] cut, logic [BOX_W-1:0] bx,
			logic [BOX_W-1:0] by, logic [BOX_W-1:0] bz, logic [ATOM_W-1:0] act,
			logic [SCR_W-1:0] scr);
		regs_t r;
		r.cutoff = cut;
		r.box_x = bx;
		r.box_y = by;
		r.box_z = bz;
		r.active = act;
		r.screen = scr;
		return r;
	endfunction

	function automatic logic [BOX_W-1:0] draw_box();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return BOX_W'($urandom_range(2 * ONE_NM, 16 * ONE_NM));
		endcase
	endfunction

	function automatic regs_t draw_regs();
		regs_t r;
		longint unsigned c;
		case ($urandom_range(0, 9))
			0: r.cutoff = '0;
			1: r.cutoff = '1;
			default: begin
				c = $urandom_range(ONE_NM / 4, 8 * ONE_NM);
				r.cutoff = CUT_W'(c * c);
			end
		endcase
		r.box_x = draw_box();
		r.box_y = draw_box();
		r.box_z = draw_box();
		case ($urandom_range(0, 9))
			0: r.active = '1;
			1: r.active = ATOM_W'($urandom_range(0, 3));
			default: r.active = ATOM_W'($urandom_range(1, 65535));
		endcase
		r.screen = SCR_W'($urandom());
		return r;
	endfunction

	// A coordinate inside the box; axes without a usable box get a small spread.
	function automatic logic signed [POS_W-1:0] box_pos(logic [BOX_W-1:0] span);
		if (span == '0 || span == '1)
			return $urandom_range(0, 16 * ONE_NM);
		return $urandom_range(0, span - 1);
	endfunction

	// Writes all six registers, with junk above the width of each one narrower than
	// the data word, then the two undecoded indexes.
	task automatic program_regs(regs_t r);
		logic [CFG_IDX_W-1:0]  idx [8];
		logic [CFG_DATA_W-1:0] val [8];
		idx[0] = REG_CUTOFF_SQ;
		val[0] = r.cutoff;
		idx[1] = REG_BOX_X;
		val[1] = {$urandom(), r.box_x};
		idx[2] = REG_BOX_Y;
		val[2] = {$urandom(), r.box_y};
		idx[3] = REG_BOX_Z;
		val[3] = {$urandom(), r.box_z};
		idx[4] = REG_ACTIVE;
		val[4] = {$urandom(), 15'($urandom()), r.active};
		idx[5] = REG_SCREEN;
		val[5] = {$urandom(), 15'($urandom()), r.screen};
		idx[6] = REG_SPARE_LO;
		val[6] = CFG_DATA_W'({$urandom(), $urandom()});
		idx[7] = REG_SPARE_HI;
		val[7] = CFG_DATA_W'({$urandom(), $urandom()});
		for (int k = 0; k < 8; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= val[k];
			pair_list.write_reg(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Called and returning at a falling edge.
	task automatic offer_particle(particle_t p);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		list_start <= p.start;
		parent_index <= p.parent;
		pos_x <= p.x;
		pos_y <= p.y;
		pos_z <= p.z;
		do
			@(posedge clk);
		while (!in_ready);
		pair_list.take_particle(p);
		@(negedge clk);
	endtask

	// A particle that yields no pair may still be scanning when the last pair
	// is out, hence the extra wait.
	task automatic drain();
		in_valid <= 1'b0;
		while (pair_list.due_count() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic random_list(regs_t r, int n);
		particle_t p;
		in_calm = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < n; k++) begin
			p.start = (k == 0);
			if ($urandom_range(0, 99) < 15) begin
				p.parent = PIDX_W'($urandom_range(0, 65536) - 1);
				p.x = $urandom();
				p.y = $urandom();
				p.z = $urandom();
			end else begin
				if (r.active == '0)
					p.parent = '0;
				else if ($urandom_range(0, 9) == 0)
					p.parent = (r.active == '1 || $urandom_range(0, 1)) ? -17'sd1 :
						PIDX_W'($urandom_range(r.active, 65535));
				else
					p.parent = PIDX_W'($urandom_range(0, r.active - 1));
				p.x = box_pos(r.box_x);
				p.y = box_pos(r.box_y);
				p.z = box_pos(r.box_z);
			end
			offer_particle(p);
		end
		in_calm = 1'b0;
	endtask

	initial begin : pair_sink
		int gap;
		int taken;
		bit calm;
		bit held;
		pair_t got;
		out_ready = 1'b0;
		taken = 0;
		calm = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			// One long hold-off, so that the block backs up and stops taking particles.
			if (hold_request && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			got.first_idx = first_index;
			got.second_idx = second_index;
			got.screen = pair_screening;
			got.last_flag = run_last;
			pair_list.match_pair(got);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[cutoff_pair_list_builder] ERROR");
		$finish;
	end

	initial begin
		regs_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		list_start = 1'b0;
		parent_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		hold_request = 1'b0;
		in_calm = 1'b0;
		pair_list = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 10 nm box, 2 nm cutoff. The list starts without list_start, straight
		// from reset.
		program_regs(make_regs(CUT_W'(64'd4 << 32), BOX_W'(10 * ONE_NM), BOX_W'(10 * ONE_NM),
			BOX_W'(10 * ONE_NM), ATOM_W'(100), SCR_W'(16'hABCD)));
		offer_particle(make_particle(1'b0, 0, 0, 0, 0));
		offer_particle(make_particle(1'b0, 1, ONE_NM, 0, 0));
		offer_particle(make_particle(1'b0, -1, 0, 0, 0));
		offer_particle(make_particle(1'b0, 100, 0, 0, 0));
		offer_particle(make_particle(1'b0, 65535, 0, 0, 0));
		// Wrap downwards, then upwards across the box edge.
		offer_particle(make_particle(1'b0, 99, 9 * ONE_NM + ONE_NM / 2, 0, 0));
		offer_particle(make_particle(1'b0, 2, ONE_NM / 2, 0, 0));
		// Exactly at the cutoff from particle 0, which must not pair.
		offer_particle(make_particle(1'b0, 3, 0, 2 * ONE_NM, 0));
		offer_particle(make_particle(1'b0, 4, 5 * ONE_NM, 5 * ONE_NM, 5 * ONE_NM));
		offer_particle(make_particle(1'b0, 5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		offer_particle(make_particle(1'b0, 6, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		drain();

		// No box at all and the widest cutoff: squares near 2^63 and saturation.
		program_regs(make_regs('1, '0, '0, '0, '1, '1));
		offer_particle(make_particle(1'b1, 65534, 0, 0, 0));
		offer_particle(make_particle(1'b0, 65535, 1, 1, 1));
		offer_particle(make_particle(1'b0, 0, 32'h7FFF_FFFF, 0, 0));
		offer_particle(make_particle(1'b0, 1, 32'h8000_0000, 0, 0));
		offer_particle(make_particle(1'b0, 7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		offer_particle(make_particle(1'b0, 8, ONE_NM, -ONE_NM, ONE_NM));
		drain();

		// Zero cutoff, largest box and no active atoms.
		program_regs(make_regs('0, '1, '1, '1, '0, SCR_W'(16'h5A5A)));
		offer_particle(make_particle(1'b1, 0, 0, 0, 0));
		offer_particle(make_particle(1'b0, 0, -1, -1, -1));
		drain();

		// Phase 2 overruns the capacity with the widest cutoff and all atoms active,
		// under the long receiver hold-off.
		for (int ph = 0; ph < 5; ph++) begin
			r = draw_regs();
			if (ph == 2) begin
				r.cutoff = '1;
				r.active = '1;
			end
			program_regs(r);
			if (ph == 2) begin
				hold_request = 1'b1;
				random_list(r, MAXP + 6);
			end else begin
				random_list(r, $urandom_range(2, 4));
				random_list(r, $urandom_range(2, 4));
			end
			drain();
		end

		if (pair_list.mismatches == 0)
			$display("[cutoff_pair_list_builder] OK");
		else
			$display("[cutoff_pair_list_builder] ERROR");
		$finish;
	end

endmodule
